>>> rtl/sol_pkg.sv
package sol_pkg;

	localparam int LIST_DEPTH_DEF = 256;
	localparam int NODE_BITS_DEF  = 12;
	localparam int COST_W         = 24;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_REMOVE = 1'b1
	} req_type_t;

	// strobe and operation shared by every cell of the chain
	typedef struct packed {
		logic      upd;
		req_type_t op;
	} cell_ctl_t;

endpackage

>>> rtl/sol_ifs.sv
interface sol_req_if #(
	parameter int NODE_BITS = sol_pkg::NODE_BITS_DEF
);
	import sol_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 req_type;
	logic [NODE_BITS-1:0] node_id;
	logic [COST_W-1:0]    entry_cost;

	modport source (output valid, output req_type, output node_id, output entry_cost,
		input ready);
	modport sink (input valid, input req_type, input node_id, input entry_cost,
		output ready);
endinterface

interface sol_rsp_if #(
	parameter int NODE_BITS = sol_pkg::NODE_BITS_DEF,
	parameter int CNT_W     = $clog2(sol_pkg::LIST_DEPTH_DEF + 1)
);
	import sol_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [1:0]           status;
	logic [CNT_W-1:0]     count;
	logic                 head_valid;
	logic [NODE_BITS-1:0] head_node;
	logic [COST_W-1:0]    head_cost;

	modport source (output valid, output status, output count, output head_valid,
		output head_node, output head_cost, input ready);
	modport sink (input valid, input status, input count, input head_valid,
		input head_node, input head_cost, output ready);
endinterface

>>> rtl/sorted_open_list_unit.sv
// Sorted open list: a chain of LIST_DEPTH cells, each holding one entry.
// The request word is captured into the s1 registers; the result word is registered
// in the output registers once they are free. A new request is accepted only after
// the result is registered; in that update all cells compare and shift at once.
// Reset clears the entry count and the handshake state; cell contents are
// undefined until written.
module sorted_open_list_unit #(
	parameter int LIST_DEPTH = sol_pkg::LIST_DEPTH_DEF,
	parameter int NODE_BITS  = sol_pkg::NODE_BITS_DEF,
	parameter int CNT_W      = $clog2(LIST_DEPTH + 1)
) (
	input  logic      clk,
	input  logic      arst_n,
	sol_req_if.sink   req,
	sol_rsp_if.source rsp
);
	import sol_pkg::*;

	logic                 busy_q;
	logic                 op_s1;
	logic [NODE_BITS-1:0] node_s1;
	logic [COST_W-1:0]    cost_s1;
	logic [CNT_W-1:0]     count_q;

	logic                 out_valid_q;
	status_t              status_q;
	logic [CNT_W-1:0]     out_count_q;
	logic                 head_valid_q;
	logic [NODE_BITS-1:0] head_node_q;
	logic [COST_W-1:0]    head_cost_q;

	logic                 ge       [LIST_DEPTH];
	logic                 match    [LIST_DEPTH];
	logic [NODE_BITS-1:0] node_q   [LIST_DEPTH];
	logic [COST_W-1:0]    cost_q   [LIST_DEPTH];
	logic [NODE_BITS-1:0] nxt_node [LIST_DEPTH];
	logic [COST_W-1:0]    nxt_cost [LIST_DEPTH];
	logic [LIST_DEPTH:0]  hit_pre;

	logic       out_free, go, found;
	status_t    status_nxt;
	logic [CNT_W-1:0] count_nxt;
	cell_ctl_t  ctl;

	assign req.ready = !busy_q;
	assign out_free  = !out_valid_q || rsp.ready;
	assign go        = busy_q && out_free;

	assign hit_pre[0] = 1'b0;
	assign found      = hit_pre[LIST_DEPTH];

	always_comb begin
		status_nxt = ST_OK;
		count_nxt  = count_q;
		case (req_type_t'(op_s1))
			REQ_INSERT: begin
				if (count_q == CNT_W'(LIST_DEPTH)) begin
					status_nxt = ST_FULL;
				end else begin
					count_nxt = count_q + CNT_W'(1);
				end
			end
			REQ_REMOVE: begin
				if (count_q == '0) begin
					status_nxt = ST_EMPTY;
				end else if (!found) begin
					status_nxt = ST_NOT_FOUND;
				end else begin
					count_nxt = count_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign ctl.upd = go && (status_nxt == ST_OK);
	assign ctl.op  = req_type_t'(op_s1);

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
		logic                 left_ge;
		logic [NODE_BITS-1:0] left_node, right_node;
		logic [COST_W-1:0]    left_cost, right_cost;
		logic                 occ;

		assign occ = CNT_W'(i) < count_q;
		assign hit_pre[i+1] = hit_pre[i] | match[i];

		if (i == 0) begin : g_head
			assign left_ge   = 1'b0;
			assign left_node = node_s1;
			assign left_cost = cost_s1;
		end else begin : g_mid
			assign left_ge   = ge[i-1];
			assign left_node = node_q[i-1];
			assign left_cost = cost_q[i-1];
		end

		if (i == LIST_DEPTH - 1) begin : g_tail
			assign right_node = node_q[i];
			assign right_cost = cost_q[i];
		end else begin : g_body
			assign right_node = node_q[i+1];
			assign right_cost = cost_q[i+1];
		end

		sol_cell #(
			.NODE_BITS (NODE_BITS)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.key_node   (node_s1),
			.key_cost   (cost_s1),
			.occ        (occ),
			.left_ge    (left_ge),
			.left_node  (left_node),
			.left_cost  (left_cost),
			.right_node (right_node),
			.right_cost (right_cost),
			.hit_before (hit_pre[i]),
			.ge         (ge[i]),
			.match      (match[i]),
			.node_q     (node_q[i]),
			.cost_q     (cost_q[i]),
			.nxt_node   (nxt_node[i]),
			.nxt_cost   (nxt_cost[i])
		);
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1   <= req.req_type;
			node_s1 <= req.node_id;
			cost_s1 <= req.entry_cost;
		end
		if (go) begin
			status_q     <= status_nxt;
			out_count_q  <= count_nxt;
			head_valid_q <= count_nxt != '0;
			head_node_q  <= (count_nxt != '0) ? nxt_node[0] : '0;
			head_cost_q  <= (count_nxt != '0) ? nxt_cost[0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				busy_q <= 1'b1;
			end else if (go) begin
				busy_q <= 1'b0;
			end
			if (go) begin
				count_q     <= count_nxt;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.count      = out_count_q;
	assign rsp.head_valid = head_valid_q;
	assign rsp.head_node  = head_node_q;
	assign rsp.head_cost  = head_cost_q;

endmodule

>>> rtl/sol_cell.sv
module sol_cell #(
	parameter int NODE_BITS = sol_pkg::NODE_BITS_DEF
) (
	input  logic                     clk,
	input  sol_pkg::cell_ctl_t       ctl,
	input  logic [NODE_BITS-1:0]     key_node,
	input  logic [sol_pkg::COST_W-1:0] key_cost,
	input  logic                     occ,
	input  logic                     left_ge,
	input  logic [NODE_BITS-1:0]     left_node,
	input  logic [sol_pkg::COST_W-1:0] left_cost,
	input  logic [NODE_BITS-1:0]     right_node,
	input  logic [sol_pkg::COST_W-1:0] right_cost,
	input  logic                     hit_before,
	output logic                     ge,
	output logic                     match,
	output logic [NODE_BITS-1:0]     node_q,
	output logic [sol_pkg::COST_W-1:0] cost_q,
	output logic [NODE_BITS-1:0]     nxt_node,
	output logic [sol_pkg::COST_W-1:0] nxt_cost
);
	import sol_pkg::*;

	// empty cells count as greater so an insert lands at the tail
	assign ge    = !occ || (cost_q >= key_cost);
	assign match = occ && (node_q == key_node);

	always_comb begin
		nxt_node = node_q;
		nxt_cost = cost_q;
		if (ctl.upd) begin
			case (ctl.op)
				REQ_INSERT: begin
					if (ge) begin
						if (left_ge) begin
							nxt_node = left_node;
							nxt_cost = left_cost;
						end else begin
							nxt_node = key_node;
							nxt_cost = key_cost;
						end
					end
				end
				REQ_REMOVE: begin
					// close the gap from the first match onward
					if (hit_before || match) begin
						nxt_node = right_node;
						nxt_cost = right_cost;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		node_q <= nxt_node;
		cost_q <= nxt_cost;
	end

endmodule

>>> test/sorted_open_list_unit_test.sv
`timescale 1ns / 1ps

module sorted_open_list_unit_test;
	import sol_pkg::*;

	localparam int DEPTH      = LIST_DEPTH_DEF;
	localparam int NBITS      = NODE_BITS_DEF;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int RAND_ITEMS = 1000;
	localparam int IDLE_LIMIT = 2000;

	typedef struct packed {
		req_type_t         op;
		logic [NBITS-1:0]  node;
		logic [COST_W-1:0] cost;
	} list_req_t;

	typedef struct packed {
		status_t           status;
		logic [CNT_W-1:0]  count;
		logic              head_valid;
		logic [NBITS-1:0]  head_node;
		logic [COST_W-1:0] head_cost;
	} list_rsp_t;

	logic clk;
	logic arst_n;

	sol_req_if #(.NODE_BITS(NBITS)) req_if ();
	sol_rsp_if #(.NODE_BITS(NBITS), .CNT_W(CNT_W)) rsp_if ();

	sorted_open_list_unit #(
		.LIST_DEPTH(DEPTH),
		.NODE_BITS (NBITS),
		.CNT_W     (CNT_W)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if.sink),
		.rsp   (rsp_if.source)
	);

	// shadow of the open list, updated as requests are queued
	logic [NBITS-1:0]  shadow_node [DEPTH];
	logic [COST_W-1:0] shadow_cost [DEPTH];
	int                shadow_count;

	list_req_t pending_words [$];
	list_rsp_t expected_rsp [$];
	int        n_queued;
	int        n_errors;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic list_rsp_t apply_request(list_req_t w);
		list_rsp_t r;
		int        pos;
		pos = 0;
		r.status = ST_OK;
		if (w.op == REQ_INSERT) begin
			if (shadow_count >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				while (pos < shadow_count && shadow_cost[pos] < w.cost)
					pos++;
				for (int k = shadow_count; k > pos; k--) begin
					shadow_node[k] = shadow_node[k-1];
					shadow_cost[k] = shadow_cost[k-1];
				end
				shadow_node[pos] = w.node;
				shadow_cost[pos] = w.cost;
				shadow_count++;
			end
		end else if (shadow_count == 0) begin
			r.status = ST_EMPTY;
		end else begin
			while (pos < shadow_count && shadow_node[pos] != w.node)
				pos++;
			if (pos >= shadow_count) begin
				r.status = ST_NOT_FOUND;
			end else begin
				for (int k = pos; k + 1 < shadow_count; k++) begin
					shadow_node[k] = shadow_node[k+1];
					shadow_cost[k] = shadow_cost[k+1];
				end
				shadow_count--;
			end
		end
		r.count      = shadow_count[CNT_W-1:0];
		r.head_valid = (shadow_count > 0);
		r.head_node  = (shadow_count > 0) ? shadow_node[0] : '0;
		r.head_cost  = (shadow_count > 0) ? shadow_cost[0] : '0;
		return r;
	endfunction

	task automatic queue_word(req_type_t op, logic [NBITS-1:0] node, logic [COST_W-1:0] cost);
		list_req_t w;
		w.op   = op;
		w.node = node;
		w.cost = cost;
		pending_words.push_back(w);
		expected_rsp.push_back(apply_request(w));
		n_queued++;
	endtask

	function automatic logic [COST_W-1:0] rand_cost();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return {COST_W{1'b1}};
			2, 3, 4: return COST_W'($urandom_range(0, 15));
			default: return COST_W'($urandom);
		endcase
	endfunction

	function automatic logic [NBITS-1:0] rand_node();
		if (shadow_count > 0 && $urandom_range(0, 4) == 0)
			return shadow_node[$urandom_range(0, shadow_count - 1)];
		return NBITS'($urandom_range(0, (1 << NBITS) - 1));
	endfunction

	// remove a handle that is held most of the time, else a random one
	task automatic queue_remove();
		if (shadow_count > 0 && $urandom_range(0, 4) != 0)
			queue_word(REQ_REMOVE, shadow_node[$urandom_range(0, shadow_count - 1)], COST_W'($urandom));
		else
			queue_word(REQ_REMOVE, NBITS'($urandom_range(0, (1 << NBITS) - 1)), COST_W'($urandom));
	endtask

	task automatic queue_mixed(int n);
		repeat (n) begin
			if ($urandom_range(0, 1) == 0)
				queue_word(REQ_INSERT, rand_node(), rand_cost());
			else
				queue_remove();
		end
	endtask

	// request driver
	list_req_t next_word;
	int        drv_gap;
	bit        drv_calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid      <= 1'b0;
			req_if.req_type   <= REQ_INSERT;
			req_if.node_id    <= '0;
			req_if.entry_cost <= '0;
			drv_gap           = 0;
			drv_calm          = 1'b0;
		end else if (!req_if.valid || req_if.ready) begin
			if (drv_gap != 0) begin
				drv_gap--;
				req_if.valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				next_word = pending_words.pop_front();
				req_if.valid      <= 1'b1;
				req_if.req_type   <= next_word.op;
				req_if.node_id    <= next_word.node;
				req_if.entry_cost <= next_word.cost;
				if ($urandom_range(0, 39) == 0)
					drv_calm = !drv_calm;
				drv_gap = drv_calm ? 0 : $urandom_range(0, 8);
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	task automatic report_mismatch(string field, longint got, longint want);
		$display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
		n_errors++;
	endtask

	// result monitor
	list_rsp_t want;
	int        mon_stall;
	bit        mon_calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			mon_stall    = 0;
			mon_calm     = 1'b0;
		end else if (rsp_if.valid && rsp_if.ready) begin
			if (expected_rsp.size() == 0) begin
				$display("%0t result word with no request outstanding", $realtime);
				n_errors++;
			end else begin
				want = expected_rsp.pop_front();
				if (rsp_if.status !== want.status)
					report_mismatch("status", rsp_if.status, want.status);
				if (rsp_if.count !== want.count)
					report_mismatch("count", rsp_if.count, want.count);
				if (rsp_if.head_valid !== want.head_valid)
					report_mismatch("head_valid", rsp_if.head_valid, want.head_valid);
				if (rsp_if.head_node !== want.head_node)
					report_mismatch("head_node", rsp_if.head_node, want.head_node);
				if (rsp_if.head_cost !== want.head_cost)
					report_mismatch("head_cost", rsp_if.head_cost, want.head_cost);
			end
			if ($urandom_range(0, 39) == 0)
				mon_calm = !mon_calm;
			mon_stall = mon_calm ? 0 : $urandom_range(0, 8);
			rsp_if.ready <= (mon_stall == 0);
		end else if (mon_stall != 0) begin
			mon_stall--;
			rsp_if.ready <= (mon_stall == 0);
		end else begin
			rsp_if.ready <= 1'b1;
		end
	end

	int idle_cycles;

	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("sorted_open_list_unit_test: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n            = 1'b0;
		shadow_count      = 0;
		n_queued          = 0;
		n_errors          = 0;

		// directed: empty list, extremes, ties, duplicates, head and tail removal
		queue_word(REQ_REMOVE, 12'h005, 24'h000000);
		queue_word(REQ_INSERT, 12'hFFF, 24'hFFFFFF);
		queue_word(REQ_INSERT, 12'h000, 24'h000000);
		queue_word(REQ_INSERT, 12'h123, 24'h000000);
		queue_word(REQ_INSERT, 12'h123, 24'h000800);
		queue_word(REQ_INSERT, 12'hABC, 24'hFFFFFF);
		queue_word(REQ_REMOVE, 12'h123, 24'hFFFFFF);
		queue_word(REQ_REMOVE, 12'h555, 24'h000000);
		queue_word(REQ_REMOVE, 12'h000, 24'h000000);
		queue_word(REQ_REMOVE, 12'hABC, 24'h000000);
		queue_word(REQ_INSERT, 12'h800, 24'h000100);
		queue_word(REQ_REMOVE, 12'hFFF, 24'h000000);
		queue_word(REQ_REMOVE, 12'h123, 24'h000000);
		queue_word(REQ_REMOVE, 12'h800, 24'h000000);
		queue_word(REQ_REMOVE, 12'h800, 24'hFFFFFF);
		queue_word(REQ_INSERT, 12'h5A5, 24'hA5A5A5);
		queue_word(REQ_INSERT, 12'hA5A, 24'h5A5A5A);
		queue_word(REQ_REMOVE, 12'h5A5, 24'hFFFFFF);
		queue_word(REQ_REMOVE, 12'hA5A, 24'h000000);

		n_queued = 0;
		queue_mixed(150);
		// fill up, hit the full list, take out the tail, refill past full, then drain
		while (shadow_count < DEPTH)
			queue_word(REQ_INSERT, rand_node(), rand_cost());
		repeat ($urandom_range(2, 5))
			queue_word(REQ_INSERT, rand_node(), rand_cost());
		queue_word(REQ_REMOVE, shadow_node[shadow_count - 1], COST_W'($urandom));
		queue_word(REQ_INSERT, rand_node(), rand_cost());
		queue_word(REQ_INSERT, rand_node(), rand_cost());
		while (shadow_count > 0)
			queue_word(REQ_REMOVE, shadow_node[$urandom_range(0, shadow_count - 1)],
				COST_W'($urandom));
		queue_remove();
		if (n_queued < RAND_ITEMS)
			queue_mixed(RAND_ITEMS - n_queued);

		repeat (9) @(posedge clk);
		arst_n = 1'b1;

		while (pending_words.size() != 0 || req_if.valid || expected_rsp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (n_errors == 0)
			$display("sorted_open_list_unit_test: PASS");
		else
			$display("sorted_open_list_unit_test: FAIL");
		$finish;
	end

endmodule

>>> sorted_open_list_unit.f
rtl/sol_pkg.sv
rtl/sol_ifs.sv
rtl/sol_cell.sv
rtl/sorted_open_list_unit.sv
test/sorted_open_list_unit_test.sv
